FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the servo pulse generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: sv/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg
// Types and constants of the servo pulse generator with byte command parser.
// ----------------------------------------------------------------------------
package spg_pkg;

  // Field and register widths
  localparam int TICK_W     = 16;
  localparam int POS_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int CH_SEL_W   = 3;
  localparam int PULSE_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_CHANNELS_DEF = 6;

  // Reset values
  localparam logic [TICK_W-1:0] RST_FRAME_PERIOD  = 16'd14999;
  localparam logic [TICK_W-1:0] RST_PULSE_WINDOW  = 16'd1750;
  localparam logic [POS_W-1:0]  RST_POSITION_BASE = 16'd500;
  localparam logic [7:0]        RST_POSITION_GAIN = 8'd5;
  localparam logic [7:0]        RST_CODE_OFFSET   = 8'd5;
  localparam logic [POS_W-1:0]  RST_POSITION      = 16'd1125;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_PERIOD  = 3'd0,
    REG_PULSE_WINDOW  = 3'd1,
    REG_POSITION_BASE = 3'd2,
    REG_POSITION_GAIN = 3'd3,
    REG_CODE_OFFSET   = 3'd4
  } reg_index_t;

  // Item kind
  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_BYTE = 1'b1
  } mode_t;

  // Command status reported with each result
  typedef enum logic [1:0] {
    ST_NONE       = 2'd0,
    ST_ID_OK      = 2'd1,
    ST_ID_BAD     = 2'd2,
    ST_POS_STORED = 2'd3
  } status_t;

  // Position store write request
  typedef struct packed {
    logic                en;
    logic [CH_SEL_W-1:0] ch;
    logic [POS_W-1:0]    value;
  } pos_wr_t;

endpackage

FILE: sv/spg_if.sv
// ----------------------------------------------------------------------------
// spg_in_if / spg_out_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface spg_in_if import spg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface spg_out_if import spg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_outputs;
  logic               in_pulse_phase;
  logic [1:0]         command_status;

  modport source (output valid, pulse_outputs, in_pulse_phase, command_status,
                  input ready);
  modport sink   (input valid, pulse_outputs, in_pulse_phase, command_status,
                  output ready);
endinterface

FILE: sv/spg_channels.sv
// ----------------------------------------------------------------------------
// spg_channels
// Per-channel position store and parallel pulse compares.
// ----------------------------------------------------------------------------
module spg_channels import spg_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pos_wr_t            wr,
  input  logic [TICK_W-1:0]  tick,
  input  logic               phase,
  input  logic [TICK_W-1:0]  window,
  output logic [PULSE_W-1:0] pulses
);

  logic [POS_W-1:0] position [NUM_CHANNELS];
  logic [POS_W-1:0] pos_eff  [NUM_CHANNELS];

  for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_ch
    // position register
    always_ff @(posedge clk) begin
      if (rst) begin
        position[k] <= RST_POSITION;
      end else if (wr.en && wr.ch == CH_SEL_W'(k)) begin
        position[k] <= wr.value;
      end
    end

    // value after this transaction's write
    assign pos_eff[k] = (wr.en && wr.ch == CH_SEL_W'(k)) ? wr.value : position[k];
  end

  // line k high in the pulse phase when tick >= window - pos, i.e. tick + pos >= window
  for (genvar k = 0; k < PULSE_W; k++) begin : g_line
    if (k < NUM_CHANNELS) begin : g_on
      assign pulses[k] = phase &&
        (({1'b0, tick} + {1'b0, pos_eff[k]}) >= {1'b0, window});
    end else begin : g_off
      assign pulses[k] = 1'b0;
    end
  end

endmodule

FILE: sv/servo_pulse_generator_byte_cmd_core.sv
// ----------------------------------------------------------------------------
// servo_pulse_generator_byte_cmd_core
// Multi-channel servo pulse generator driven by tick and command byte items.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result. An item is captured in an input
// register, processed by one pass of logic (frame counter step, position
// multiply-add-clamp and the parallel channel compares) and written into the
// result register; one item per clock is sustained while results are taken.
// The result register lets a new item be taken while a result waits; the
// input stalls only when both stages hold an item.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// and should only change while no item is in flight.
module servo_pulse_generator_byte_cmd_core import spg_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  spg_in_if.sink                in_ch,
  spg_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  // configuration
  logic [TICK_W-1:0] frame_period;
  logic [TICK_W-1:0] pulse_window;
  logic [POS_W-1:0]  position_base;
  logic [7:0]        position_gain;
  logic [7:0]        code_offset;

  // frame and parser state
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic                pulse_phase, pulse_phase_next;
  logic                awaiting_position, awaiting_position_next;
  logic [CH_SEL_W-1:0] selected_channel, selected_channel_next;

  // input stage
  logic              s1_valid;
  logic              s1_mode;
  logic [BYTE_W-1:0] s1_byte;

  // result stage
  logic               o_valid;
  logic [PULSE_W-1:0] o_pulses;
  logic               o_phase;
  status_t            o_status;

  logic               adv;
  logic [TICK_W-1:0]  phase_limit;
  logic [7:0]         code_diff;
  logic [15:0]        code_prod;
  logic [POS_W:0]     pos_sum;
  logic [POS_W-1:0]   pos_clamped;
  status_t            status_next;
  pos_wr_t            pos_wr;
  logic [PULSE_W-1:0] pulses_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period  <= RST_FRAME_PERIOD;
      pulse_window  <= RST_PULSE_WINDOW;
      position_base <= RST_POSITION_BASE;
      position_gain <= RST_POSITION_GAIN;
      code_offset   <= RST_CODE_OFFSET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_PERIOD:  frame_period  <= cfg_data;
        REG_PULSE_WINDOW:  pulse_window  <= cfg_data;
        REG_POSITION_BASE: position_base <= cfg_data;
        REG_POSITION_GAIN: position_gain <= cfg_data[7:0];
        REG_CODE_OFFSET:   code_offset   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves when the result register is free or drained
  assign adv          = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_mode <= in_ch.mode;
      s1_byte <= in_ch.rx_byte;
    end
  end

  // phase end: pulse window, or frame minus window saturated at zero
  always_comb begin
    if (pulse_phase) begin
      phase_limit = pulse_window;
    end else if (frame_period > pulse_window) begin
      phase_limit = frame_period - pulse_window;
    end else begin
      phase_limit = '0;
    end
  end

  // position code: base + (code - offset, floored at zero) * gain, clamped to the window
  assign code_diff   = (s1_byte > code_offset) ? (s1_byte - code_offset) : 8'd0;
  assign code_prod   = code_diff * position_gain;
  assign pos_sum     = {1'b0, position_base} + {1'b0, code_prod};
  assign pos_clamped = (pos_sum > {1'b0, pulse_window}) ? pulse_window
                                                        : pos_sum[POS_W-1:0];

  // item processing
  always_comb begin
    tick_count_next        = tick_count;
    pulse_phase_next       = pulse_phase;
    awaiting_position_next = awaiting_position;
    selected_channel_next  = selected_channel;
    status_next            = ST_NONE;
    pos_wr                 = '0;
    if (s1_mode == MODE_TICK) begin
      if (tick_count >= phase_limit) begin
        tick_count_next  = '0;
        pulse_phase_next = !pulse_phase;
      end else begin
        tick_count_next  = tick_count + 1'b1;
      end
    end else if (awaiting_position) begin
      pos_wr.en              = adv;
      pos_wr.ch              = selected_channel;
      pos_wr.value           = pos_clamped;
      awaiting_position_next = 1'b0;
      status_next            = ST_POS_STORED;
    end else if (s1_byte < BYTE_W'(NUM_CHANNELS)) begin
      selected_channel_next  = s1_byte[CH_SEL_W-1:0];
      awaiting_position_next = 1'b1;
      status_next            = ST_ID_OK;
    end else begin
      status_next            = ST_ID_BAD;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count        <= '0;
      pulse_phase       <= 1'b0;
      awaiting_position <= 1'b0;
      selected_channel  <= '0;
    end else if (adv) begin
      tick_count        <= tick_count_next;
      pulse_phase       <= pulse_phase_next;
      awaiting_position <= awaiting_position_next;
      selected_channel  <= selected_channel_next;
    end
  end

  // channel positions and compares
  spg_channels #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_channels (
    .clk    (clk),
    .rst    (rst),
    .wr     (pos_wr),
    .tick   (tick_count_next),
    .phase  (pulse_phase_next),
    .window (pulse_window),
    .pulses (pulses_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_pulses <= pulses_next;
      o_phase  <= pulse_phase_next;
      o_status <= status_next;
    end
  end

  assign out_ch.valid          = o_valid;
  assign out_ch.pulse_outputs  = o_pulses;
  assign out_ch.in_pulse_phase = o_phase;
  assign out_ch.command_status = o_status;

  // checks
  `ASSERT_IMPLY(a_stall_only_full, clk, rst, !in_ch.ready, s1_valid && o_valid)
  `ASSERT_IMPLY(a_idle_lines_low, clk, rst, o_valid && !o_phase, o_pulses == '0)
  `ASSERT_NEXT(a_id_arms_parser, clk, rst, adv && status_next == ST_ID_OK,
               awaiting_position)
  `ASSERT_NEXT(a_store_disarms, clk, rst, adv && status_next == ST_POS_STORED,
               !awaiting_position && o_status == ST_POS_STORED)

endmodule
